// ----- hdl/hrt_pkg.sv -----
// Package for the heartbeat response tracker.
// Holds sizes, opcodes, state codes and ms scaling constants; no dependencies.
package hrt_pkg;

  localparam int unsigned NODES   = 32;
  localparam int unsigned NODE_AW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int unsigned CNT_W   = $clog2(NODES + 1);

  localparam int unsigned TS_W    = 48;
  localparam int unsigned MASK_W  = 32;
  localparam int unsigned IDX_W   = 5;
  localparam int unsigned MS_W    = 10;
  localparam int unsigned SLOTS   = 3;

  // elapsed time is clamped below 1024 ms, so the dividend fits 20 bits;
  // ms = (us * MS_RECIP) >> RECIP_SH is exact for every us below 2^20
  localparam int unsigned REM_W    = 20;
  localparam int unsigned RECIP_W  = 21;
  localparam int unsigned PROD_W   = REM_W + RECIP_W;
  localparam int unsigned RECIP_SH = 30;
  localparam logic [REM_W-1:0]   DIV_LIMIT = REM_W'(1024000);
  localparam logic [REM_W-1:0]   SAT_REM   = REM_W'(1023000);
  localparam logic [RECIP_W-1:0] MS_RECIP  = RECIP_W'(1073742);

  typedef enum logic [1:0] {
    OP_PING  = 2'd0,
    OP_PONG  = 2'd1,
    OP_CHECK = 2'd2
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_DIV   = 4'b0010,
    ST_SWEEP = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

endpackage

// ----- hdl/hrt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Standalone; used for the per-node response times.
module hrt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- hdl/heartbeat_response_tracker.sv -----
// Heartbeat response tracker top level.
// Uses hrt_pkg and hrt_ram (response time store).
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one request: opcode_i,
//   node_index_i, timestamp_us_i. Ping stores the send timestamp. Pong turns
//   the elapsed time into ms and records it for the node. Check sweeps all
//   nodes and returns one result on the output channel (out_valid_o /
//   out_ready_i): the responder mask and the three slowest nodes.
//   Steps: ping registers the send time; pong registers the clamped elapsed
//   time, scaled in the DIV state by a fixed reciprocal of 1000 in one
//   multiply; check runs SWEEP, one RAM read and one ranking step per node.
//   Throughput: one request at a time; in_ready_o is high only when idle.
//   Ping and pong are taken while a result still waits on the output.
//   If a check finishes while the previous result is not yet taken, it
//   holds until out_ready_i frees the output register.
//   Reset clears the send time, the reply flags and the output valid; the
//   time store is not cleared, entries are used only after a pong wrote them.
module heartbeat_response_tracker import hrt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         opcode_i,
  input  logic [5:0]         node_index_i,
  input  logic [TS_W-1:0]    timestamp_us_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [MASK_W-1:0]  responder_mask_o,
  output logic [IDX_W-1:0]   slow_node_first_o,
  output logic [MS_W-1:0]    slow_time_first_o,
  output logic [IDX_W-1:0]   slow_node_second_o,
  output logic [MS_W-1:0]    slow_time_second_o,
  output logic [IDX_W-1:0]   slow_node_third_o,
  output logic [MS_W-1:0]    slow_time_third_o
);

  state_e state_q, state_d;

  logic [TS_W-1:0]    send_time_q;
  logic [NODES-1:0]   flags_q;
  logic [NODES-1:0]   mask_q;
  logic [REM_W-1:0]   rem_q;
  logic [NODE_AW-1:0] node_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               rd_vld_q;
  logic [NODE_AW-1:0] rd_idx_q;
  logic [IDX_W-1:0]   slot_idx_q [SLOTS];
  logic [MS_W-1:0]    slot_tm_q  [SLOTS];
  logic [IDX_W-1:0]   slot_idx_d [SLOTS];
  logic [MS_W-1:0]    slot_tm_d  [SLOTS];
  logic               out_valid_q;
  logic [MASK_W-1:0]  mask_out_q;
  logic [IDX_W-1:0]   out_idx_q [SLOTS];
  logic [MS_W-1:0]    out_tm_q  [SLOTS];

  logic               in_fire;
  op_e                op;
  logic               node_ok;
  logic [TS_W-1:0]    diff;
  logic               backward;
  logic               saturate;
  logic [REM_W-1:0]   rem_init;
  logic [PROD_W-1:0]  prod;
  logic [MS_W-1:0]    ms_val;
  logic               ram_we;
  logic [MS_W-1:0]    rd_time;
  logic               rank_en;
  logic               sweep_end;
  logic               out_load;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign op         = op_e'(opcode_i);
  assign node_ok    = ({1'b0, node_index_i} < 7'(NODES));

  // elapsed time setup for the ms scaling
  assign diff     = timestamp_us_i - send_time_q;
  assign backward = (timestamp_us_i < send_time_q);
  assign saturate = (|diff[TS_W-1:REM_W]) || (diff[REM_W-1:0] >= DIV_LIMIT);
  assign rem_init = backward ? '0 : (saturate ? SAT_REM : diff[REM_W-1:0]);

  // us to ms by reciprocal multiply
  assign prod     = PROD_W'(rem_q) * PROD_W'(MS_RECIP);
  assign ms_val   = prod[RECIP_SH +: MS_W];
  assign ram_we   = (state_q == ST_DIV);

  assign sweep_end = (state_q == ST_SWEEP) && (cnt_q == CNT_W'(NODES));
  assign out_load  = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  hrt_ram #(
    .WIDTH (MS_W),
    .DEPTH (NODES)
  ) u_times (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (node_q),
    .wdata_i (ms_val),
    .raddr_i (cnt_q[NODE_AW-1:0]),
    .rdata_o (rd_time)
  );

  // ranking: strictly greater enters, later slots shift down
  assign rank_en = rd_vld_q && mask_q[rd_idx_q];

  always_comb begin
    slot_idx_d = slot_idx_q;
    slot_tm_d  = slot_tm_q;
    if (rank_en) begin
      if (rd_time > slot_tm_q[0]) begin
        slot_idx_d[2] = slot_idx_q[1];
        slot_tm_d[2]  = slot_tm_q[1];
        slot_idx_d[1] = slot_idx_q[0];
        slot_tm_d[1]  = slot_tm_q[0];
        slot_idx_d[0] = IDX_W'(rd_idx_q);
        slot_tm_d[0]  = rd_time;
      end else if (rd_time > slot_tm_q[1]) begin
        slot_idx_d[2] = slot_idx_q[1];
        slot_tm_d[2]  = slot_tm_q[1];
        slot_idx_d[1] = IDX_W'(rd_idx_q);
        slot_tm_d[1]  = rd_time;
      end else if (rd_time > slot_tm_q[2]) begin
        slot_idx_d[2] = IDX_W'(rd_idx_q);
        slot_tm_d[2]  = rd_time;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (op == OP_PONG && node_ok) begin
            state_d = ST_DIV;
          end else if (op == OP_CHECK) begin
            state_d = ST_SWEEP;
          end
        end
      end
      ST_DIV: begin
        state_d = ST_IDLE;
      end
      ST_SWEEP: begin
        if (sweep_end) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      send_time_q <= '0;
      flags_q     <= '0;
      cnt_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_fire && op == OP_PING) begin
        send_time_q <= timestamp_us_i;
      end
      if (in_fire && op == OP_CHECK) begin
        flags_q <= '0;
      end else if (ram_we) begin
        flags_q[node_q] <= 1'b1;
      end
      if (in_fire) begin
        cnt_q <= '0;
      end else if (state_q == ST_SWEEP && !sweep_end) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      rd_vld_q <= (state_q == ST_SWEEP) && !sweep_end;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rem_q  <= rem_init;
      node_q <= node_index_i[NODE_AW-1:0];
    end
    rd_idx_q <= cnt_q[NODE_AW-1:0];
    if (in_fire && op == OP_CHECK) begin
      mask_q <= flags_q;
      for (int s = 0; s < SLOTS; s++) begin
        slot_idx_q[s] <= '0;
        slot_tm_q[s]  <= '0;
      end
    end else begin
      slot_idx_q <= slot_idx_d;
      slot_tm_q  <= slot_tm_d;
    end
    if (out_load) begin
      mask_out_q <= MASK_W'(mask_q);
      out_idx_q  <= slot_idx_q;
      out_tm_q   <= slot_tm_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign responder_mask_o   = mask_out_q;
  assign slow_node_first_o  = out_idx_q[0];
  assign slow_time_first_o  = out_tm_q[0];
  assign slow_node_second_o = out_idx_q[1];
  assign slow_time_second_o = out_tm_q[1];
  assign slow_node_third_o  = out_idx_q[2];
  assign slow_time_third_o  = out_tm_q[2];

  a_rise_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result raised outside of sweep completion");

  a_slot_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_tm_q[0] >= out_tm_q[1]) && (out_tm_q[1] >= out_tm_q[2]))
    else $error("slow slots out of order");

  a_empty_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_tm_q[2] == '0) |-> (out_idx_q[2] == '0))
    else $error("empty slot carries a node index");

  a_check_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && op == OP_CHECK) |=> (flags_q == '0))
    else $error("reply flags not cleared by check");

endmodule
